>>> sv/positional_list_store_top_defines.svh
// Assertion macros for the positional list store checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef POSITIONAL_LIST_STORE_TOP_DEFINES_SVH
`define POSITIONAL_LIST_STORE_TOP_DEFINES_SVH

// Clocked check, switched off while reset is held
`define PLS_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Clocked check that also holds during reset
`define PLS_ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/pls_pkg.sv
// Package for the positional list store: sizes, operation and status codes,
// and the control bundle driven into the cell chain. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pls_pkg;

    // List depth and derived widths
    localparam int C_DEPTH = 32;
    localparam int C_IDX_W = $clog2(C_DEPTH);
    localparam int C_CNT_W = $clog2(C_DEPTH + 1);
    localparam int C_VAL_W = 32;
    localparam int C_OP_W  = 3;
    localparam int C_POS_W = 6;
    localparam int C_STS_W = 2;
    localparam int C_OCNT_W = 6;
    // compare width wide enough for count + 1 and any position
    localparam int C_CMP_W = ((C_CNT_W > C_POS_W) ? C_CNT_W : C_POS_W) + 1;

    // Stream payload widths
    localparam int C_S_TDATA_W = 48;
    localparam int C_M_TDATA_W = 40;

    typedef enum logic [C_OP_W-1:0] {
        OP_INS_HEAD = 3'd0,
        OP_INS_TAIL = 3'd1,
        OP_INS_AT   = 3'd2,
        OP_DEL_HEAD = 3'd3,
        OP_DEL_TAIL = 3'd4,
        OP_DEL_AT   = 3'd5,
        OP_READ_AT  = 3'd6,
        OP_NOP      = 3'd7
    } t_op;

    typedef enum logic [C_STS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // Broadcast to every cell of the chain
    typedef struct packed {
        logic               ins;   // open a gap at idx and load the new value
        logic               del;   // close the gap at idx
        logic               pick;  // cell at idx drives its value out
        logic [C_IDX_W-1:0] idx;
    } t_cell_ctrl;

endpackage

`default_nettype wire

>>> sv/pls_cell.sv
// One storage cell of the list chain: holds a value and shifts toward or
// away from the head on a positional insert or delete. Uses pls_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pls_cell (
    input  wire                           i_clk,
    input  wire [pls_pkg::C_IDX_W-1:0]    i_index,   // this cell's place in the chain
    input  wire pls_pkg::t_cell_ctrl      i_ctrl,
    input  wire [pls_pkg::C_VAL_W-1:0]    i_value,   // value of an insert request
    input  wire [pls_pkg::C_VAL_W-1:0]    i_left,    // neighbor toward the head
    input  wire [pls_pkg::C_VAL_W-1:0]    i_right,   // neighbor toward the tail
    output logic [pls_pkg::C_VAL_W-1:0]   o_data,
    output logic [pls_pkg::C_VAL_W-1:0]   o_pick     // own value when selected, else zero
);
    import pls_pkg::*;

    logic [C_VAL_W-1:0] r_data;
    logic [C_VAL_W-1:0] n_data;
    logic               w_at;
    logic               w_behind;

    assign w_at     = (i_index == i_ctrl.idx);
    assign w_behind = (i_index > i_ctrl.idx);

    // Next value: load, take from head side, take from tail side, or hold
    always_comb begin
        n_data = r_data;
        if (i_ctrl.ins) begin
            if (w_at) begin
                n_data = i_value;
            end else if (w_behind) begin
                n_data = i_left;
            end
        end else if (i_ctrl.del) begin
            if (w_at || w_behind) begin
                n_data = i_right;
            end
        end
    end

    // Payload only, no reset
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_pick = (i_ctrl.pick && w_at) ? r_data : '0;

endmodule

`default_nettype wire

>>> sv/pls_ctrl.sv
// Operation decoder for the list: checks count and position, picks the
// chain index and works out status and new count. Uses pls_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pls_ctrl (
    input  wire                           i_fire,    // request accepted this cycle
    input  wire pls_pkg::t_op             i_op,
    input  wire [pls_pkg::C_POS_W-1:0]    i_position,
    input  wire [pls_pkg::C_CNT_W-1:0]    i_count,
    output pls_pkg::t_cell_ctrl           o_ctrl,
    output pls_pkg::t_status              o_status,
    output logic [pls_pkg::C_CNT_W-1:0]   o_count_nxt
);
    import pls_pkg::*;

    logic [C_CMP_W-1:0] w_cnt;
    logic [C_CMP_W-1:0] w_pos;
    logic               w_full;
    logic               w_empty;
    logic               w_ins;
    logic               w_del;
    logic               w_pick;
    logic [C_IDX_W-1:0] w_idx;

    assign w_cnt   = C_CMP_W'(i_count);
    assign w_pos   = C_CMP_W'(i_position);
    assign w_full  = (w_cnt >= C_CMP_W'(C_DEPTH));
    assign w_empty = (i_count == '0);

    // Decode the request
    always_comb begin
        o_status = ST_OK;
        w_ins    = 1'b0;
        w_del    = 1'b0;
        w_pick   = 1'b0;
        w_idx    = '0;
        unique case (i_op) inside
            OP_INS_HEAD, OP_INS_TAIL, OP_INS_AT: begin
                if (w_full) begin
                    o_status = ST_FULL;
                end else if (i_op == OP_INS_HEAD) begin
                    w_ins = 1'b1;
                end else if (i_op == OP_INS_TAIL) begin
                    w_ins = 1'b1;
                    w_idx = C_IDX_W'(i_count);
                end else if (w_pos == '0 || w_pos > w_cnt + C_CMP_W'(1)) begin
                    o_status = ST_RANGE;
                end else begin
                    w_ins = 1'b1;
                    w_idx = C_IDX_W'(w_pos - C_CMP_W'(1));
                end
            end
            OP_DEL_HEAD, OP_DEL_TAIL, OP_DEL_AT, OP_READ_AT: begin
                if (w_empty) begin
                    o_status = ST_EMPTY;
                end else if (i_op == OP_DEL_HEAD) begin
                    w_del  = 1'b1;
                    w_pick = 1'b1;
                end else if (i_op == OP_DEL_TAIL) begin
                    w_del  = 1'b1;
                    w_pick = 1'b1;
                    w_idx  = C_IDX_W'(w_cnt - C_CMP_W'(1));
                end else if (w_pos == '0 || w_pos > w_cnt) begin
                    o_status = ST_RANGE;
                end else begin
                    w_del  = (i_op == OP_DEL_AT);
                    w_pick = 1'b1;
                    w_idx  = C_IDX_W'(w_pos - C_CMP_W'(1));
                end
            end
            default: begin
                o_status = ST_OK;
            end
        endcase
    end

    // Chain control only moves cells on an accepted request
    always_comb begin
        o_ctrl.ins  = w_ins && i_fire;
        o_ctrl.del  = w_del && i_fire;
        o_ctrl.pick = w_pick;
        o_ctrl.idx  = w_idx;
    end

    // New count
    always_comb begin
        if (w_ins) begin
            o_count_nxt = i_count + C_CNT_W'(1);
        end else if (w_del) begin
            o_count_nxt = i_count - C_CNT_W'(1);
        end else begin
            o_count_nxt = i_count;
        end
    end

endmodule

`default_nettype wire

>>> sv/positional_list_store_top.sv
// Positional list store top level: stream ports, decoder, cell chain and
// output register. Depends on pls_pkg, pls_ctrl and pls_cell.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   Requests arrive on the s_axis channel, one list operation each (insert
//   head/tail/at, delete head/tail/at, read at). Every request yields exactly
//   one response on the m_axis channel: status, count after the operation,
//   and the removed or read value (zero when nothing is returned).
//   The list is a chain of cells, one value each; a positional insert or
//   delete shifts all cells behind the position in the same cycle.
//   The response is valid in the cycle after the request is accepted.
//   Throughput: one request per cycle while m_axis_tready is high.
//   The response sits in an output register; s_axis_tready is high whenever
//   that register is empty or is being emptied in the same cycle. If the
//   receiver stalls, one response waits and further requests are held off.
//   Reset (synchronous, active low) empties the list and drops any pending
//   response; cell contents are not cleared and are never read while empty.

module positional_list_store_top (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    // [2:0] op, [34:3] value, [40:35] position, [47:41] zero
    input  wire [pls_pkg::C_S_TDATA_W-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    // [1:0] status, [7:2] count, [39:8] value_out
    output logic [pls_pkg::C_M_TDATA_W-1:0]  m_axis_tdata
);
    import pls_pkg::*;

    logic                 w_fire;
    t_op                  w_op;
    logic [C_VAL_W-1:0]   w_value;
    logic [C_POS_W-1:0]   w_position;
    t_cell_ctrl           w_ctrl;
    t_status              w_status;
    logic [C_CNT_W-1:0]   w_count_nxt;
    logic [C_VAL_W-1:0]   w_data [C_DEPTH];
    logic [C_VAL_W-1:0]   w_pick [C_DEPTH];
    logic [C_VAL_W-1:0]   w_vout;

    logic [C_CNT_W-1:0]   r_count;
    logic                 r_m_valid;
    t_status              r_status;
    logic [C_OCNT_W-1:0]  r_ocount;
    logic [C_VAL_W-1:0]   r_vout;

    // Unpack request
    assign w_op       = t_op'(s_axis_tdata[2:0]);
    assign w_value    = s_axis_tdata[34:3];
    assign w_position = s_axis_tdata[40:35];

    // Handshake
    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign w_fire        = s_axis_tvalid && s_axis_tready;

    pls_ctrl u_ctrl (
        .i_fire      (w_fire),
        .i_op        (w_op),
        .i_position  (w_position),
        .i_count     (r_count),
        .o_ctrl      (w_ctrl),
        .o_status    (w_status),
        .o_count_nxt (w_count_nxt)
    );

    // Cell chain, head at index 0
    for (genvar g = 0; g < C_DEPTH; g++) begin : g_cell
        logic [C_VAL_W-1:0] w_left;
        logic [C_VAL_W-1:0] w_right;
        if (g == 0) begin : g_head
            assign w_left = '0;
        end else begin : g_mid
            assign w_left = w_data[g-1];
        end
        if (g == C_DEPTH - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_body
            assign w_right = w_data[g+1];
        end
        pls_cell u_cell (
            .i_clk   (i_clk),
            .i_index (C_IDX_W'(g)),
            .i_ctrl  (w_ctrl),
            .i_value (w_value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[g]),
            .o_pick  (w_pick[g])
        );
    end

    // Selected cell value: at most one cell drives nonzero
    always_comb begin
        w_vout = '0;
        for (int i = 0; i < C_DEPTH; i++) begin
            w_vout = w_vout | w_pick[i];
        end
    end

    // Count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_fire) begin
            r_count <= w_count_nxt;
        end
    end

    // Response valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_fire) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    // Response payload
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_status <= w_status;
            r_ocount <= C_OCNT_W'(w_count_nxt);
            r_vout   <= w_vout;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {r_vout, r_ocount, r_status};

endmodule

`default_nettype wire

>>> sv/pls_checker.sv
// Port-level checks for positional_list_store_top, bound to the top level.
// Depends on pls_pkg and positional_list_store_top_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "positional_list_store_top_defines.svh"

module pls_checker (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              s_axis_tvalid,
    input  wire                              s_axis_tready,
    input  wire                              m_axis_tvalid,
    input  wire                              m_axis_tready,
    // [1:0] status, [7:2] count, [39:8] value_out
    input  wire [pls_pkg::C_M_TDATA_W-1:0]   m_axis_tdata
);
    import pls_pkg::*;

    logic w_s_fire;
    logic w_status_err;

    assign w_s_fire     = s_axis_tvalid && s_axis_tready;
    assign w_status_err = (m_axis_tdata[1:0] != ST_OK);

    // Stalled response holds
    `PLS_ASSERT_RST(a_resp_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "response changed while stalled")

    // Reset drops any pending response
    `PLS_ASSERT_CLK(a_reset_clears, i_clk, !i_rst_n |=> !m_axis_tvalid, "response valid after reset")

    // Every accepted request gives a response in the next cycle
    `PLS_ASSERT_RST(a_one_cycle, i_clk, i_rst_n, w_s_fire |=> m_axis_tvalid, "no response after accepted request")

    // Count never exceeds the list depth
    `PLS_ASSERT_RST(a_count_bound, i_clk, i_rst_n, m_axis_tvalid |-> (m_axis_tdata[7:2] <= C_OCNT_W'(C_DEPTH)), "count above depth")

    // Failed operations return no value
    `PLS_ASSERT_RST(a_err_zero, i_clk, i_rst_n, m_axis_tvalid && w_status_err |-> (m_axis_tdata[39:8] == '0), "value returned on error status")

endmodule

bind positional_list_store_top pls_checker u_pls_checker (.*);

`default_nettype wire
